FILE: rtl/pmpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmpt_pkg
// Types and constants shared by the xorshift128 memory pattern tester.
// ----------------------------------------------------------------------------
package pmpt_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned SEEDS    = 4;
	localparam int unsigned SHIFT_A  = 11;
	localparam int unsigned SHIFT_B  = 8;
	localparam int unsigned SHIFT_C  = 19;
	localparam int unsigned REG_IDX_W = 2;

	typedef enum logic {
		ACT_GENERATE = 1'b0,
		ACT_CHECK    = 1'b1
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SEED0 = 2'd0,
		REG_SEED1 = 2'd1,
		REG_SEED2 = 2'd2,
		REG_SEED3 = 2'd3
	} reg_idx_t;

	typedef logic [SEEDS-1:0][WORD_W-1:0] word_set_t;

	typedef struct packed {
		action_t           action;
		logic              restart;
		logic              first_in_block;
		logic [WORD_W-1:0] mem_word;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  pattern_or_diff;
		logic               word_error;
		logic               block_error;
		logic [COUNT_W-1:0] block_count;
	} result_t;

endpackage : pmpt_pkg
`default_nettype wire

FILE: rtl/pmpt_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmpt_engine
// Generator state, sticky block error and block counter; one xorshift128
// step per item, result computed combinationally from the current state.
// ----------------------------------------------------------------------------
module pmpt_engine
	import pmpt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire item_t     item,
	input  wire word_set_t seed,
	output result_t        result
);

	word_set_t          gen_q;
	logic               sticky_q;
	logic [COUNT_W-1:0] count_q;

	word_set_t          base;
	word_set_t          gen_next;
	logic [WORD_W-1:0]  t_a;
	logic [WORD_W-1:0]  t_b;
	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  diff;
	logic               check;
	logic               werr;
	logic               sticky_next;
	logic [COUNT_W-1:0] count_base;
	logic [COUNT_W-1:0] count_next;

	always_comb begin
		check = (item.action == ACT_CHECK);
		base  = item.restart ? seed : gen_q;
		t_a   = base[3] ^ (base[3] << SHIFT_A);
		t_b   = t_a ^ (t_a >> SHIFT_B);
		word  = t_b ^ base[0] ^ (base[0] >> SHIFT_C);
		gen_next = {base[2], base[1], base[0], word};
		diff  = check ? (word ^ item.mem_word) : word;
		werr  = check && (diff != '0);
		count_base  = (item.restart && check) ? '0 : count_q;
		count_next  = count_base;
		sticky_next = sticky_q;
		if (check && item.first_in_block) begin
			count_next  = count_base + COUNT_W'(1);
			sticky_next = 1'b0;
		end
		sticky_next = sticky_next | werr;
		result.pattern_or_diff = diff;
		result.word_error      = werr;
		result.block_error     = sticky_next;
		result.block_count     = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q    <= '0;
			sticky_q <= 1'b0;
			count_q  <= '0;
		end else if (step) begin
			gen_q    <= gen_next;
			sticky_q <= sticky_next;
			count_q  <= count_next;
		end
	end

endmodule : pmpt_engine
`default_nettype wire

FILE: rtl/prng_memory_pattern_tester_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prng_memory_pattern_tester_unit
// xorshift128 memory pattern generator and read-back checker.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata mem_word; tuser action,restart,first
// m_*      out  m_tvalid/m_tready    tdata pattern_or_diff,block_count; tuser errs
// cfg_*    in   cfg_valid/cfg_ready  cfg_index seed register, cfg_data value
//
// One request per cycle unless the output stalls; each request passes the input
// register, then the result register; the generator step is a few XORs in between.
// Reset clears seeds, generator state, block error and block counter.
// A stalled output holds its result; input is still taken while a stage frees.
// ----------------------------------------------------------------------------
module prng_memory_pattern_tester_unit
	import pmpt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [WORD_W-1:0]    s_tdata,   // [31:0] mem_word
	input  wire logic [2:0]           s_tuser,   // [0] action, [1] restart, [2] first_in_block
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [47:0]               m_tdata,   // [31:0] pattern_or_diff, [47:32] block_count
	output logic [1:0]                m_tuser,   // [0] word_error, [1] block_error
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	word_set_t seed_q;
	item_t     in_s1;
	logic      vld_s1;
	result_t   out_s2;
	logic      vld_s2;
	item_t     in_item;
	result_t   res;
	logic      advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEED0: seed_q[0] <= cfg_data;
				REG_SEED1: seed_q[1] <= cfg_data;
				REG_SEED2: seed_q[2] <= cfg_data;
				REG_SEED3: seed_q[3] <= cfg_data;
				default:   seed_q    <= seed_q;
			endcase
		end
	end

	always_comb begin
		in_item.action         = action_t'(s_tuser[0]);
		in_item.restart        = s_tuser[1];
		in_item.first_in_block = s_tuser[2];
		in_item.mem_word       = s_tdata;
	end

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1 <= in_item;
		end
	end

	pmpt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (in_s1),
		.seed   (seed_q),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {out_s2.block_count, out_s2.pattern_or_diff};
	assign m_tuser  = {out_s2.block_error, out_s2.word_error};

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result register not loaded after advance");

	a_word_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tuser[1])
		else $error("word error without block error");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted request not held in input stage");

	a_restart_check_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_s1.restart && (in_s1.action == ACT_CHECK)) |=>
		(out_s2.block_count == {{(COUNT_W-1){1'b0}}, $past(in_s1.first_in_block)}))
		else $error("block counter not cleared on check restart");

endmodule : prng_memory_pattern_tester_unit
`default_nettype wire
